[rtl/core/sdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants for the signed decimal field formatter
// field widths, ascii codes and the converter-to-emitter handoff record
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int VALUE_W       = 32;
  localparam int PAD_W         = 8;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W     = $clog2(VALUE_W);
  localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
  localparam int MAX_CHARS_DEF = 11;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // converted number handed to the character emitter
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
    logic [PAD_W-1:0] pad_width;
  } conv_result_t;

endpackage

[rtl/core/sdf_bcd_conv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_bcd_conv: bit-serial binary to bcd converter
// shift-and-add-3 over the magnitude, one input bit per cycle
// ----------------------------------------------------------------------------
module sdf_bcd_conv (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [sdf_pkg::VALUE_W-1:0]      value,
  input  logic [sdf_pkg::PAD_W-1:0]        pad_width,
  output logic                             res_valid,
  input  logic                             res_ready,
  output sdf_pkg::conv_result_t            res
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_DONE = 3'b100
  } conv_state_t;

  conv_state_t                       state;
  logic [sdf_pkg::VALUE_W-1:0]       mag;
  logic [sdf_pkg::BIT_CNT_W-1:0]     bit_cnt;
  logic [sdf_pkg::BCD_W-1:0]         bcd;
  logic [sdf_pkg::BCD_W-1:0]         bcd_adj;
  logic                              neg;
  logic [sdf_pkg::PAD_W-1:0]         width;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] =
          bcd[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] =
          bcd[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      bit_cnt <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (req_valid) begin
            state   <= C_RUN;
            bit_cnt <= '0;
          end
        end
        C_RUN: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == {sdf_pkg::BIT_CNT_W{1'b1}}) begin
            state <= C_DONE;
          end
        end
        C_DONE: begin
          if (res_ready) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && req_valid) begin
      neg   <= value[sdf_pkg::VALUE_W-1];
      mag   <= value[sdf_pkg::VALUE_W-1] ? ('0 - value) : value;
      width <= pad_width;
      bcd   <= '0;
    end else if (state == C_RUN) begin
      bcd <= {bcd_adj[sdf_pkg::BCD_W-2:0], mag[sdf_pkg::VALUE_W-1]};
      mag <= {mag[sdf_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign req_ready     = (state == C_IDLE);
  assign res_valid     = (state == C_DONE);
  assign res.bcd       = bcd;
  assign res.neg       = neg;
  assign res.pad_width = width;

endmodule

[rtl/core/sdf_char_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_char_emit: character sequencer with output register
// pad spaces, optional minus sign, then digits most significant first
// ----------------------------------------------------------------------------
module sdf_char_emit #(
  parameter int MAX_CHARS = sdf_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  output logic                          res_ready,
  input  sdf_pkg::conv_result_t         res,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sdf_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last
);

  localparam int CW = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_EMIT = 2'b10
  } emit_state_t;

  emit_state_t                          state;
  logic [sdf_pkg::DIGIT_W-1:0]          digs [sdf_pkg::NUM_DIGITS];
  logic [sdf_pkg::DIG_IDX_W-1:0]        idx;
  logic [CW-1:0]                        spc;
  logic                                 sgn;

  logic [sdf_pkg::DIG_IDX_W-1:0]        top_idx;
  logic [CW-1:0]                        len;
  logic [CW-1:0]                        wsat;
  logic [CW-1:0]                        pad;
  logic                                 take;

  // highest nonzero digit; zero keeps a single digit
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < sdf_pkg::NUM_DIGITS; i++) begin
      if (res.bcd[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] != '0) begin
        top_idx = sdf_pkg::DIG_IDX_W'(i);
      end
    end
    len  = CW'(top_idx) + CW'(1) + CW'(res.neg);
    wsat = (res.pad_width > sdf_pkg::PAD_W'(MAX_CHARS)) ? CW'(MAX_CHARS)
                                                        : CW'(res.pad_width);
    pad  = (wsat > len) ? (wsat - len) : '0;
  end

  assign take      = !out_valid || out_ready;
  assign res_ready = (state == E_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new character loads the register, otherwise it drains on accept
      if (state == E_EMIT && take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        E_IDLE: begin
          if (res_valid) begin
            state <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (take) begin
            if (spc == '0 && !sgn && idx == '0) begin
              state <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && res_valid) begin
      for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
        digs[i] <= res.bcd[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];
      end
      idx <= top_idx;
      spc <= pad;
      sgn <= res.neg;
    end else if (state == E_EMIT && take) begin
      if (spc != '0) begin
        out_char <= sdf_pkg::CH_SPACE;
        out_last <= 1'b0;
        spc      <= spc - 1'b1;
      end else if (sgn) begin
        out_char <= sdf_pkg::CH_MINUS;
        out_last <= 1'b0;
        sgn      <= 1'b0;
      end else begin
        out_char <= sdf_pkg::CH_ZERO + sdf_pkg::CHAR_W'(digs[idx]);
        out_last <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/signed_decimal_field_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: signed 32-bit value to right-justified ascii
// streams one field per request, space padded, minus sign before the digits
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata fields (low bit first)          tuser  tlast
//  s_axis    in   value[31:0], pad_width[39:32]          -      -
//  m_axis    out  char_code[7:0]                         -      last char
//
// - a request is loaded, run through shift-and-add-3 over all 32 magnitude
//   bits in the bit-serial converter, handed off, then streamed one character
//   per cycle while m_tready is high (1 to MAX_CHARS characters when
//   MAX_CHARS >= 11) from the emitter's output register
// - the converter takes the next request while the emitter still streams
//   the previous field, so conversion overlaps the previous field's output
// - rst is synchronous and clears the control state of both stages
// - m_tready low holds the current character and stalls the emitter; the
//   converter then waits in its done state with s_tready low
//
module signed_decimal_field_formatter #(
  parameter int MAX_CHARS = sdf_pkg::MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], pad_width[39:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // char_code[7:0]
  output logic        m_tlast
);

  // handoff between converter and emitter
  logic                  res_valid;
  logic                  res_ready;
  sdf_pkg::conv_result_t res;

  // bit-serial binary to bcd, one magnitude bit per cycle
  sdf_bcd_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .value     (s_tdata[sdf_pkg::VALUE_W-1:0]),
    .pad_width (s_tdata[sdf_pkg::VALUE_W +: sdf_pkg::PAD_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // spaces, sign and digits out through the output register
  sdf_char_emit #(
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
